@@ src/bosc_pkg.sv @@
// types and constants shared by the second-order barometer compensation core
package bosc_pkg;

  localparam int unsigned AdcBits = 24;
  localparam int unsigned RawW    = 24;
  localparam int unsigned CalW    = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [RawW-1:0] AdcMask = RawW'((64'd1 << AdcBits) - 64'd1);

  localparam logic [CfgIdxW-1:0] RegC1 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegC2 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegC3 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegC4 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegC5 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegC6 = 3'd5;

  localparam logic signed [18:0] ColdOffset = 19'sd3500;
  localparam logic [15:0]        TempBase   = 16'd2000;

  localparam int unsigned NStages = 9;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } bosc_in_t;

  typedef struct packed {
    logic signed [31:0] pressure_centi_mbar;
    logic signed [15:0] temperature_centi_deg;
  } bosc_out_t;

endpackage

@@ src/baro_second_order_compensation_core.sv @@
// top level of the second-order barometer compensation core
//
// Input channel: in_valid_i, in_word_i, in_stall_o. One word carries a raw
// pressure and a raw temperature conversion and is taken at a clock edge with
// in_valid_i high and in_stall_o low.
// Output channel: out_valid_o, out_word_o, out_stall_i. One word per input
// word: compensated pressure (hundredths of millibar) and temperature
// (hundredths of a degree).
// Calibration: cfg_valid_i, cfg_index_i, cfg_data_i, cfg_ready_o (always
// high). Indices 0 to 5 select calibration words one to six, others are
// ignored. Write only while the core holds no word.
// The nine register stages lie between acceptance and out_valid_o, the first
// of which takes the word at the accepting edge (three multiplier ranks, split
// 24 by 40 bit pressure product).
// Throughput is one word per cycle while out_stall_i is low.
// Each stage moves when it is empty or the stage after it moves, so a stall on
// the output fills the empty stages before in_stall_o rises; nothing is
// dropped or repeated. Reset empties the pipeline and clears the calibration.
module baro_second_order_compensation_core
  import bosc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  bosc_in_t           in_word_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output bosc_out_t          out_word_o,
  input  logic               out_stall_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CalW-1:0]    cfg_data_i,
  output logic               cfg_ready_o
);

  logic [CalW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

  logic [NStages:1] v_q;
  logic [NStages:1] rdy;

  // stage 1
  logic [RawW-1:0]    d1_1_q;
  logic signed [24:0] dt_q, dt_d;
  // stage 2
  logic [RawW-1:0]    d1_2_q;
  logic signed [41:0] dtc6_q, dtc6_d, c4dt_q, c4dt_d, c3dt_q, c3dt_d;
  logic signed [49:0] dtdt_full;
  logic [47:0]        dtdt_q;
  // stage 3
  logic [RawW-1:0]    d1_3_q;
  logic signed [17:0] t_q, t_d;
  logic signed [34:0] off_3_q, off_3_d;
  logic signed [33:0] sens_3_q, sens_3_d;
  logic [16:0]        t2_q;
  // stage 4
  logic [RawW-1:0]    d1_4_q;
  logic signed [34:0] off_4_q;
  logic signed [33:0] sens_4_q;
  logic [15:0]        temp_4_q, temp_4_d;
  logic signed [18:0] tp;
  logic signed [35:0] tt_full;
  logic signed [37:0] uu_full;
  logic [34:0]        tt_q, uu_q;
  logic               tneg_q, tcold_q;
  // stage 5
  logic [RawW-1:0]    d1_5_q;
  logic signed [34:0] off_5_q;
  logic signed [33:0] sens_5_q;
  logic [15:0]        temp_5_q;
  logic [37:0]        off2_q, off2_d, sens2_q, sens2_d;
  logic [37:0]        tt5, base2, u7;
  logic [38:0]        u11;
  // stage 6
  logic [RawW-1:0]    d1_6_q;
  logic [15:0]        temp_6_q;
  logic signed [39:0] off_6_q, off_6_d, sens_6_q, sens_6_d;
  // stage 7
  logic [15:0]        temp_7_q;
  logic signed [39:0] off_7_q;
  logic signed [44:0] pp_hi_q, pp_hi_d;
  logic [43:0]        pp_lo_q;
  // stage 8
  logic [15:0]        temp_8_q;
  logic signed [39:0] off_8_q;
  logic signed [63:0] prod_q, prod_d;
  // stage 9, output
  logic signed [43:0] acc;
  bosc_out_t          res_q, res_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegC1:   c1_q <= cfg_data_i;
        RegC2:   c2_q <= cfg_data_i;
        RegC3:   c3_q <= cfg_data_i;
        RegC4:   c4_q <= cfg_data_i;
        RegC5:   c5_q <= cfg_data_i;
        RegC6:   c6_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ready chain, from the output back
  always_comb begin
    rdy[NStages] = !v_q[NStages] || !out_stall_i;
    for (int k = NStages - 1; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage arithmetic
  always_comb begin
    dt_d = $signed({1'b0, in_word_i.raw_temperature & AdcMask})
         - $signed({1'b0, c5_q, 8'b0});

    dtc6_d    = 42'(dt_q) * 42'($signed({1'b0, c6_q}));
    c4dt_d    = 42'(dt_q) * 42'($signed({1'b0, c4_q}));
    c3dt_d    = 42'(dt_q) * 42'($signed({1'b0, c3_q}));
    dtdt_full = 50'(dt_q) * 50'(dt_q);

    t_d      = $signed(dtc6_q[40:23]);
    off_3_d  = $signed({3'b0, c2_q, 16'b0}) + 35'($signed(c4dt_q[40:7]));
    sens_3_d = $signed({3'b0, c1_q, 15'b0}) + 34'($signed(c3dt_q[40:8]));

    tp       = 19'(t_q) + ColdOffset;
    tt_full  = 36'(t_q) * 36'(t_q);
    uu_full  = 38'(tp) * 38'(tp);
    // second-order temperature term only below 20 degrees
    temp_4_d = t_q[15:0] + TempBase - (t_q[17] ? t2_q[15:0] : 16'd0);

    tt5   = {1'b0, tt_q, 2'b0} + {3'b0, tt_q};
    base2 = {1'b0, tt5[37:1]};
    u7    = {uu_q, 3'b0} - {3'b0, uu_q};
    u11   = {1'b0, uu_q, 3'b0} + {3'b0, uu_q, 1'b0} + {4'b0, uu_q};
    off2_d  = '0;
    sens2_d = '0;
    if (tneg_q) begin
      off2_d  = base2;
      sens2_d = {1'b0, base2[37:1]};
      if (tcold_q) begin
        off2_d  = base2 + u7;
        sens2_d = {1'b0, base2[37:1]} + u11[38:1];
      end
    end

    off_6_d  = 40'(off_5_q) - 40'($signed({1'b0, off2_q}));
    sens_6_d = 40'(sens_5_q) - 40'($signed({1'b0, sens2_q}));

    pp_hi_d = 45'($signed({1'b0, d1_6_q})) * 45'($signed(sens_6_q[39:20]));

    prod_d = (64'(pp_hi_q) <<< 20) + $signed({20'b0, pp_lo_q});

    acc = 44'($signed(prod_q[63:21])) - 44'(off_8_q);
    res_d.pressure_centi_mbar   = 32'($signed(acc[43:15]));
    res_d.temperature_centi_deg = $signed(temp_8_q);
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      d1_1_q <= in_word_i.raw_pressure & AdcMask;
      dt_q   <= dt_d;
    end
    if (rdy[2]) begin
      d1_2_q <= d1_1_q;
      dtc6_q <= dtc6_d;
      c4dt_q <= c4dt_d;
      c3dt_q <= c3dt_d;
      dtdt_q <= dtdt_full[47:0];
    end
    if (rdy[3]) begin
      d1_3_q   <= d1_2_q;
      t_q      <= t_d;
      off_3_q  <= off_3_d;
      sens_3_q <= sens_3_d;
      t2_q     <= dtdt_q[47:31];
    end
    if (rdy[4]) begin
      d1_4_q   <= d1_3_q;
      off_4_q  <= off_3_q;
      sens_4_q <= sens_3_q;
      temp_4_q <= temp_4_d;
      tt_q     <= tt_full[34:0];
      uu_q     <= uu_full[34:0];
      tneg_q   <= t_q[17];
      tcold_q  <= tp[18];
    end
    if (rdy[5]) begin
      d1_5_q   <= d1_4_q;
      off_5_q  <= off_4_q;
      sens_5_q <= sens_4_q;
      temp_5_q <= temp_4_q;
      off2_q   <= off2_d;
      sens2_q  <= sens2_d;
    end
    if (rdy[6]) begin
      d1_6_q   <= d1_5_q;
      temp_6_q <= temp_5_q;
      off_6_q  <= off_6_d;
      sens_6_q <= sens_6_d;
    end
    if (rdy[7]) begin
      temp_7_q <= temp_6_q;
      off_7_q  <= off_6_q;
      pp_hi_q  <= pp_hi_d;
      pp_lo_q  <= {20'b0, d1_6_q} * {24'b0, sens_6_q[19:0]};
    end
    if (rdy[8]) begin
      temp_8_q <= temp_7_q;
      off_8_q  <= off_7_q;
      prod_q   <= prod_d;
    end
    if (rdy[9]) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = v_q[NStages];
  assign out_word_o  = res_q;

endmodule
